// ===== rtl/cd39_pkg.sv =====
// ----------------------------------------------------------------------------
// cd39_pkg
// Shared constants, types and symbol tables for the code 39 bar-width decoder.
// ----------------------------------------------------------------------------
package cd39_pkg;

    localparam int TIME_W            = 64;
    localparam int DEBOUNCE_W        = 20;
    localparam int PIN_W             = 5;
    localparam int DURATION_BITS_DEF = 32;

    localparam int BAR_COUNT    = 9;
    localparam int BAR_IDX_W    = 4;
    localparam int WIDE_COUNT   = 3;
    localparam int PASS_W       = 2;
    localparam int SYMBOL_COUNT = 43;
    localparam int SYM_IDX_W    = 6;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    localparam logic [PIN_W-1:0]      SENSOR_PIN     = 5'd18;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd1000;
    localparam logic [8:0]            DELIM_PATTERN  = 9'h094;
    localparam logic [6:0]            DELIM_ASCII    = 7'd42;
    localparam logic [6:0]            ERROR_ASCII    = 7'd107;

    // result status codes
    localparam logic [2:0] ST_START   = 3'd0;
    localparam logic [2:0] ST_DATA    = 3'd1;
    localparam logic [2:0] ST_FRAME   = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // input actions
    localparam logic ACT_EDGE  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic       done;
        logic [8:0] pattern;
    } t_rank_stat;

    typedef struct packed {
        logic start;
        logic delim;
        logic rev;
    } t_match_cmd;

    typedef struct packed {
        logic       done;
        logic       found;
        logic       set_rev;
        logic [6:0] ascii;
    } t_match_res;

    function automatic logic [8:0] cd39_rev9(input logic [8:0] p);
        logic [8:0] r;
        for (int i = 0; i < 9; i++) begin
            r[8-i] = p[i];
        end
        return r;
    endfunction

    function automatic logic [8:0] cd39_sym_pattern(input logic [SYM_IDX_W-1:0] idx);
        logic [8:0] p;
        case (idx)
            6'd0:  p = 9'h034;
            6'd1:  p = 9'h121;
            6'd2:  p = 9'h061;
            6'd3:  p = 9'h160;
            6'd4:  p = 9'h031;
            6'd5:  p = 9'h130;
            6'd6:  p = 9'h070;
            6'd7:  p = 9'h025;
            6'd8:  p = 9'h124;
            6'd9:  p = 9'h064;
            6'd10: p = 9'h109;
            6'd11: p = 9'h049;
            6'd12: p = 9'h148;
            6'd13: p = 9'h019;
            6'd14: p = 9'h118;
            6'd15: p = 9'h058;
            6'd16: p = 9'h00D;
            6'd17: p = 9'h10C;
            6'd18: p = 9'h04C;
            6'd19: p = 9'h01C;
            6'd20: p = 9'h103;
            6'd21: p = 9'h043;
            6'd22: p = 9'h142;
            6'd23: p = 9'h013;
            6'd24: p = 9'h112;
            6'd25: p = 9'h052;
            6'd26: p = 9'h007;
            6'd27: p = 9'h106;
            6'd28: p = 9'h046;
            6'd29: p = 9'h016;
            6'd30: p = 9'h181;
            6'd31: p = 9'h0C1;
            6'd32: p = 9'h1C0;
            6'd33: p = 9'h091;
            6'd34: p = 9'h190;
            6'd35: p = 9'h0D0;
            6'd36: p = 9'h085;
            6'd37: p = 9'h184;
            6'd38: p = 9'h0A8;
            6'd39: p = 9'h0A2;
            6'd40: p = 9'h08A;
            6'd41: p = 9'h02A;
            6'd42: p = 9'h0C4;
            default: p = 9'h000;
        endcase
        return p;
    endfunction

    function automatic logic [6:0] cd39_sym_ascii(input logic [SYM_IDX_W-1:0] idx);
        logic [6:0] a;
        if (idx < 6'd10) begin
            a = 7'h30 + {1'b0, idx};
        end else if (idx < 6'd36) begin
            a = 7'h37 + {1'b0, idx};
        end else begin
            case (idx)
                6'd36:   a = 7'h2D;
                6'd37:   a = 7'h2E;
                6'd38:   a = 7'h24;
                6'd39:   a = 7'h2F;
                6'd40:   a = 7'h2B;
                6'd41:   a = 7'h25;
                6'd42:   a = 7'h20;
                default: a = 7'h00;
            endcase
        end
        return a;
    endfunction

endpackage

// ===== rtl/cd39_rank.sv =====
// ----------------------------------------------------------------------------
// cd39_rank
// Marks the three widest of nine bars with one shared comparator: three
// max-search passes over the bar store, lower index wins a tie.
// ----------------------------------------------------------------------------
module cd39_rank #(
    parameter int DURATION_BITS = cd39_pkg::DURATION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DURATION_BITS-1:0] i_dur [cd39_pkg::BAR_COUNT],
    output cd39_pkg::t_rank_stat     o_stat
);
    import cd39_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [PASS_W-1:0]        r_pass;
    logic [BAR_IDX_W-1:0]     r_idx;
    logic                     r_have;
    logic [DURATION_BITS-1:0] r_best_val;
    logic [BAR_IDX_W-1:0]     r_best_idx;
    logic [BAR_COUNT-1:0]     r_taken;

    logic                 cand;
    logic [BAR_IDX_W-1:0] cur_best_idx;
    logic [8:0]           pattern;

    // strict compare keeps the lower index on equal widths
    assign cand = !r_taken[r_idx] && (!r_have || (i_dur[r_idx] > r_best_val));
    assign cur_best_idx = cand ? r_idx : r_best_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_idx == BAR_IDX_W'(BAR_COUNT - 1))
                     && (r_pass == PASS_W'(WIDE_COUNT - 1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pass  <= '0;
            r_idx   <= '0;
            r_have  <= 1'b0;
            r_taken <= '0;
        end else if (r_busy) begin
            if (cand) begin
                r_best_val <= i_dur[r_idx];
                r_best_idx <= r_idx;
            end
            if (r_idx == BAR_IDX_W'(BAR_COUNT - 1)) begin
                r_taken[cur_best_idx] <= 1'b1;
                r_idx  <= '0;
                r_have <= 1'b0;
                r_pass <= r_pass + PASS_W'(1);
            end else begin
                r_idx <= r_idx + BAR_IDX_W'(1);
                if (cand) begin
                    r_have <= 1'b1;
                end
            end
        end
    end

    // first bar lands in the top bit
    always_comb begin
        for (int i = 0; i < BAR_COUNT; i++) begin
            pattern[BAR_COUNT-1-i] = r_taken[i];
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.pattern = pattern;

endmodule

// ===== rtl/cd39_match.sv =====
// ----------------------------------------------------------------------------
// cd39_match
// Matches a wide/narrow pattern against the delimiter in one step, or scans
// the 43-entry symbol table one entry per cycle with a single comparator.
// ----------------------------------------------------------------------------
module cd39_match (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cd39_pkg::t_match_cmd i_cmd,
    input  logic [8:0]           i_pattern,
    output cd39_pkg::t_match_res o_res
);
    import cd39_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_found;
    logic                 r_set_rev;
    logic [6:0]           r_ascii;
    logic [SYM_IDX_W-1:0] r_idx;
    logic                 r_rev;

    logic [8:0] entry;
    logic       hit;

    assign entry = r_rev ? cd39_rev9(cd39_sym_pattern(r_idx)) : cd39_sym_pattern(r_idx);
    assign hit   = (i_pattern == entry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= !i_cmd.delim;
            r_done <= i_cmd.delim;
        end else if (r_busy && (hit || (r_idx == SYM_IDX_W'(SYMBOL_COUNT - 1)))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx <= '0;
            r_rev <= i_cmd.rev;
            if (i_cmd.delim) begin
                if (i_pattern == DELIM_PATTERN) begin
                    r_found   <= 1'b1;
                    r_set_rev <= 1'b0;
                    r_ascii   <= DELIM_ASCII;
                end else if (i_pattern == cd39_rev9(DELIM_PATTERN)) begin
                    r_found   <= 1'b1;
                    r_set_rev <= 1'b1;
                    r_ascii   <= DELIM_ASCII;
                end else begin
                    r_found   <= 1'b0;
                    r_set_rev <= 1'b0;
                    r_ascii   <= '0;
                end
            end else begin
                r_found   <= 1'b0;
                r_set_rev <= 1'b0;
                r_ascii   <= '0;
            end
        end else if (r_busy) begin
            if (hit) begin
                r_found <= 1'b1;
                r_ascii <= cd39_sym_ascii(r_idx);
            end else begin
                r_idx <= r_idx + SYM_IDX_W'(1);
            end
        end
    end

    assign o_res.done    = r_done;
    assign o_res.found   = r_found;
    assign o_res.set_rev = r_set_rev;
    assign o_res.ascii   = r_ascii;

endmodule

// ===== rtl/code39_bar_width_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// code39_bar_width_decoder_unit
// Debounces sensor edges, collects nine bar widths and decodes code 39 frames.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one event word: tuser is the action (edge or clear),
//   tdata the timestamp and pin. m_axis returns one status word for each
//   completed group of nine bars; other events give no word.
//   the debounce register is written on the cfg channel, which is always
//   ready; write it only while no event is in flight.
// sequence:
//   an event is taken only while the sequencer is idle. a clear or an edge on
//   another pin ends at the difference step; any other edge goes on to the
//   debounce check. the ninth bar then runs three max-search passes over nine
//   bars on one comparator, then the delimiter check or a symbol table scan
//   one entry a cycle, and then the status emit step.
// reset:
//   synchronous, active low; debounce returns to 1000 us, bar count, arming and
//   frame state clear, no clearing pass is needed.
// stall:
//   a status word sits in the output register until taken; the next event is
//   accepted meanwhile, and a new status waits for the register to free up.
// ----------------------------------------------------------------------------
module code39_bar_width_decoder_unit #(
    parameter int DURATION_BITS = cd39_pkg::DURATION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cfg: debounce_us
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cd39_pkg::DEBOUNCE_W-1:0]  i_cfg_data,
    // edge_time [63:0], pin_number [68:64], zero pad
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cd39_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action [0]
    input  logic [cd39_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // symbol [6:0], held_symbol [13:7], reversed [14], zero pad
    output logic [cd39_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // status [2:0]
    output logic [cd39_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
    import cd39_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_RANK  = 3'd3;
    localparam logic [2:0] S_MATCH = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [TIME_W-1:0] DUR_CAP = {TIME_W{1'b1}} >> (TIME_W - DURATION_BITS);

    logic [2:0]               r_state;
    logic                     r_act;
    logic [TIME_W-1:0]        r_time;
    logic [PIN_W-1:0]         r_pin;
    logic [TIME_W-1:0]        r_last;
    logic [TIME_W-1:0]        r_diff;
    logic [DEBOUNCE_W-1:0]    r_debounce;
    logic                     r_armed;
    logic [BAR_IDX_W-1:0]     r_bar_count;
    logic [DURATION_BITS-1:0] r_dur [BAR_COUNT];
    logic [1:0]               r_char_pos;
    logic                     r_rev;
    logic [6:0]               r_held;

    logic                     r_m_valid;
    logic [2:0]               r_m_status;
    logic [6:0]               r_m_symbol;
    logic [6:0]               r_m_held;
    logic                     r_m_rev;

    logic                     passed;
    logic                     last_bar;
    logic [DURATION_BITS-1:0] sat_dur;
    logic [1:0]               pos_next;
    logic                     pos_delim;
    logic                     out_free;
    logic                     rev_after;
    logic [2:0]               n_status;

    t_rank_stat rank_stat;
    t_match_cmd match_cmd;
    t_match_res match_res;

    assign passed    = r_diff > {{(TIME_W - DEBOUNCE_W){1'b0}}, r_debounce};
    assign last_bar  = r_bar_count == BAR_IDX_W'(BAR_COUNT - 1);
    assign sat_dur   = (r_diff > DUR_CAP) ? DUR_CAP[DURATION_BITS-1:0]
                                          : r_diff[DURATION_BITS-1:0];
    assign pos_next  = r_char_pos + 2'd1;
    assign pos_delim = (pos_next == 2'd1) || (pos_next == 2'd3);
    assign out_free  = !r_m_valid || m_axis_tready;
    assign rev_after = r_rev || match_res.set_rev;

    always_comb begin
        if (!match_res.found) begin
            n_status = ST_INVALID;
        end else if (pos_next == 2'd1) begin
            n_status = ST_START;
        end else if (pos_next == 2'd3) begin
            n_status = ST_FRAME;
        end else begin
            n_status = ST_DATA;
        end
    end

    assign match_cmd.start = (r_state == S_RANK) && rank_stat.done;
    assign match_cmd.delim = pos_delim;
    assign match_cmd.rev   = r_rev;

    cd39_rank #(
        .DURATION_BITS(DURATION_BITS)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_CHECK) && passed && r_armed && last_bar),
        .i_dur   (r_dur),
        .o_stat  (rank_stat)
    );

    cd39_match u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (match_cmd),
        .i_pattern (rank_stat.pattern),
        .o_res     (match_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            r_debounce <= i_cfg_data;
        end
    end

    // input word capture and the bar store
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && s_axis_tvalid) begin
            r_act  <= s_axis_tuser[0];
            r_time <= s_axis_tdata[TIME_W-1:0];
            r_pin  <= s_axis_tdata[TIME_W +: PIN_W];
        end
        if (r_state == S_DIFF) begin
            r_diff <= r_time - r_last;
        end
        if ((r_state == S_CHECK) && passed && r_armed) begin
            r_dur[r_bar_count] <= sat_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_armed     <= 1'b0;
            r_bar_count <= '0;
            r_char_pos  <= '0;
            r_rev       <= 1'b0;
            r_held      <= ERROR_ASCII;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    if (r_act == ACT_CLEAR) begin
                        r_armed     <= 1'b0;
                        r_bar_count <= '0;
                        r_state     <= S_IDLE;
                    end else if (r_pin != SENSOR_PIN) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= S_IDLE;
                    if (passed) begin
                        r_last <= r_time;
                        if (!r_armed) begin
                            r_armed <= 1'b1;
                        end else begin
                            r_bar_count <= r_bar_count + BAR_IDX_W'(1);
                            if (last_bar) begin
                                r_state <= S_RANK;
                            end
                        end
                    end
                end
                S_RANK: begin
                    if (rank_stat.done) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    if (match_res.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_armed     <= 1'b0;
                        r_bar_count <= '0;
                        r_state     <= S_IDLE;
                        if ((n_status == ST_INVALID) || (n_status == ST_FRAME)) begin
                            r_char_pos <= '0;
                            r_rev      <= 1'b0;
                        end else begin
                            r_char_pos <= pos_next;
                            r_rev      <= rev_after;
                        end
                        if (n_status == ST_INVALID) begin
                            r_held <= ERROR_ASCII;
                        end else if (n_status == ST_DATA) begin
                            r_held <= match_res.ascii;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_m_status <= n_status;
            r_m_symbol <= match_res.ascii;
            r_m_held   <= (n_status == ST_FRAME) ? r_held : 7'd0;
            r_m_rev    <= rev_after;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {1'b0, r_m_rev, r_m_held, r_m_symbol};

`ifndef ASSERT_OFF
    a_invalid_no_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == ST_INVALID) == (m_axis_tdata[6:0] == 7'd0)))
        else $error("symbol does not agree with invalid status");

    a_frame_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FRAME)) |-> (m_axis_tdata[13:7] != 7'd0))
        else $error("frame complete without a held data character");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_pos != 2'd3)
        else $error("character position left at the closing delimiter");

    a_bars_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_bar_count < BAR_IDX_W'(BAR_COUNT)))
        else $error("bar store overflow while idle");
`endif

endmodule

// ===== dv/tb_code39_bar_width_decoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_code39_bar_width_decoder_unit
// Streams timestamped sensor edges and clears into the code 39 decoder. A
// local model of the bar store, the wide-bar ranking and the frame tracker
// predicts every status word, and the monitor checks each one as it leaves.
// Phases change the debounce time and the idle and stall rates on both sides.
// ----------------------------------------------------------------------------
module tb_code39_bar_width_decoder_unit;
    import cd39_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;

    localparam logic [8:0] CODE_PATTERNS [0:42] = '{
        9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
        9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
        9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
        9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0, 9'h085, 9'h184, 9'h0A8, 9'h0A2,
        9'h08A, 9'h02A, 9'h0C4
    };
    // first character in the top byte
    localparam logic [43*8-1:0] CODE_CHARS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-.$/+% ";

    typedef struct packed {
        logic        action;
        logic [63:0] edge_time;
        logic [4:0]  pin;
    } t_sensor_event;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] symbol;
        logic [6:0] held;
        logic       rev;
    } t_decode_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [DEBOUNCE_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    t_sensor_event  pending_events[$];
    t_sensor_event  event_in_flight;
    t_decode_result expected_results[$];
    t_decode_result oldest_result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int pushed_events  = 0;

    // model state
    logic [DEBOUNCE_W-1:0] p_debounce  = DEBOUNCE_RESET;
    logic [63:0]           p_last_edge = '0;
    logic [31:0]           p_bars [0:8];
    int                    p_bar_count = 0;
    logic                  p_armed     = 1'b0;
    int                    p_char_pos  = 0;
    logic                  p_reverse   = 1'b0;
    logic [6:0]            p_held      = ERROR_ASCII;

    // stimulus side view of the last accepted edge
    logic [63:0]           gen_clock    = '0;
    logic [DEBOUNCE_W-1:0] gen_debounce = DEBOUNCE_RESET;

    code39_bar_width_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // edge_time, pin_number, zero pad
        .s_axis_tdata  (s_axis_tdata),
        // action
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // symbol, held_symbol, reversed, zero pad
        .m_axis_tdata  (m_axis_tdata),
        // status
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic logic [8:0] flip9(input logic [8:0] p);
        logic [8:0] r;
        for (int i = 0; i < 9; i++) begin
            r[8-i] = p[i];
        end
        return r;
    endfunction

    function automatic logic [6:0] code_char(input int idx);
        logic [7:0] c;
        c = CODE_CHARS[(42-idx)*8 +: 8];
        return c[6:0];
    endfunction

    // wide = one of the three longest bars, lower index wins a tie
    function automatic logic [8:0] wide_bits();
        logic [8:0] p;
        int         rank;
        p = '0;
        for (int i = 0; i < 9; i++) begin
            rank = 0;
            for (int j = 0; j < 9; j++) begin
                if (p_bars[j] > p_bars[i] || (p_bars[j] == p_bars[i] && j < i)) begin
                    rank++;
                end
            end
            if (rank < 3) begin
                p[8-i] = 1'b1;
            end
        end
        return p;
    endfunction

    task automatic clear_bar_store();
        for (int i = 0; i < 9; i++) begin
            p_bars[i] = '0;
        end
        p_bar_count = 0;
        p_armed     = 1'b0;
    endtask

    task automatic predict_event(input t_sensor_event ev);
        logic [63:0]    diff;
        logic [8:0]     pat;
        logic [6:0]     sym;
        t_decode_result r;
        if (ev.action == ACT_CLEAR) begin
            clear_bar_store();
            return;
        end
        if (ev.pin != SENSOR_PIN) begin
            return;
        end
        diff = ev.edge_time - p_last_edge;
        if (diff <= {44'd0, p_debounce}) begin
            return;
        end
        if (!p_armed) begin
            p_armed = 1'b1;
        end else begin
            p_bars[p_bar_count] = (diff > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
            p_bar_count++;
            if (p_bar_count >= 9) begin
                p_char_pos = (p_char_pos + 1) & 3;
                pat = wide_bits();
                sym = '0;
                if (p_char_pos == 1 || p_char_pos == 3) begin
                    if (pat == DELIM_PATTERN) begin
                        sym = DELIM_ASCII;
                    end else if (pat == flip9(DELIM_PATTERN)) begin
                        p_reverse = 1'b1;
                        sym = DELIM_ASCII;
                    end
                end else begin
                    for (int i = 0; i < 43; i++) begin
                        if (sym == '0 &&
                            pat == (p_reverse ? flip9(CODE_PATTERNS[i]) : CODE_PATTERNS[i])) begin
                            sym = code_char(i);
                        end
                    end
                end
                r.held   = '0;
                r.symbol = sym;
                if (sym == '0) begin
                    r.status = ST_INVALID;
                end else if (p_char_pos == 1) begin
                    r.status = ST_START;
                end else if (p_char_pos == 3) begin
                    r.status = ST_FRAME;
                    r.held   = p_held;
                end else begin
                    r.status = ST_DATA;
                    p_held   = sym;
                end
                r.rev = p_reverse;
                expected_results.push_back(r);
                if (r.status == ST_INVALID) begin
                    p_held     = ERROR_ASCII;
                    p_char_pos = 0;
                    p_reverse  = 1'b0;
                end else if (r.status == ST_FRAME) begin
                    p_char_pos = 0;
                    p_reverse  = 1'b0;
                end
                clear_bar_store();
            end
        end
        p_last_edge = ev.edge_time;
    endtask

    // ------------------------------------------------------------------------
    // driver, receiver and checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_event(event_in_flight);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    event_in_flight = pending_events.pop_front();
                    s_axis_tdata  <= {3'b000, event_in_flight.pin, event_in_flight.edge_time};
                    s_axis_tuser  <= event_in_flight.action;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input t_decode_result want);
        if (fail_count < 10) begin
            $display("%0t %s: exp status %0d sym %h held %h rev %0d,",
                     $realtime, what, want.status, want.symbol, want.held, want.rev);
            $display("    got status %0d sym %h held %h rev %0d",
                     m_axis_tuser[2:0], m_axis_tdata[6:0], m_axis_tdata[13:7], m_axis_tdata[14]);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected word", '0);
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_axis_tuser[2:0] != oldest_result.status ||
                        m_axis_tdata[6:0] != oldest_result.symbol ||
                        m_axis_tdata[13:7] != oldest_result.held ||
                        m_axis_tdata[14] != oldest_result.rev) begin
                        note_mismatch("word mismatch", oldest_result);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_edge(input logic [63:0] t, input logic [4:0] pin);
        t_sensor_event ev;
        ev.action    = ACT_EDGE;
        ev.edge_time = t;
        ev.pin       = pin;
        pending_events.push_back(ev);
        pushed_events++;
        if (pin == SENSOR_PIN && (t - gen_clock) > {44'd0, gen_debounce}) begin
            gen_clock = t;
        end
    endtask

    task automatic push_clear();
        t_sensor_event ev;
        ev.action    = ACT_CLEAR;
        ev.edge_time = {$urandom, $urandom};
        ev.pin       = 5'($urandom_range(0, 31));
        pending_events.push_back(ev);
        pushed_events++;
    endtask

    function automatic logic [4:0] other_pin();
        logic [4:0] p;
        p = 5'($urandom_range(0, 30));
        if (p >= SENSOR_PIN) begin
            p = p + 5'd1;
        end
        return p;
    endfunction

    // an edge that the debounce or the pin filter drops
    task automatic push_bounce();
        if ($urandom_range(0, 1) == 0) begin
            push_edge({$urandom, $urandom}, other_pin());
        end else begin
            push_edge(gen_clock + $urandom_range(0, gen_debounce), SENSOR_PIN);
        end
    endtask

    task automatic emit_group(input logic [8:0] pattern);
        logic [31:0] base;
        logic [63:0] dur;
        push_edge(gen_clock + gen_debounce + 1 + $urandom_range(0, 500), SENSOR_PIN);
        base = gen_debounce + 1 + $urandom_range(0, 2000);
        for (int i = 0; i < 9; i++) begin
            if (pattern[8-i]) begin
                dur = 2 * {32'd0, base} + $urandom_range(0, base);
                if ($urandom_range(0, 32) == 0) begin
                    dur = {$urandom, $urandom} | 64'h1_0000_0000;
                end
            end else begin
                dur = {32'd0, base} + $urandom_range(0, base / 4);
            end
            if ($urandom_range(0, 9) == 0) begin
                push_bounce();
            end
            push_edge(gen_clock + dur, SENSOR_PIN);
            if ($urandom_range(0, 59) == 0) begin
                push_clear();
            end
        end
    endtask

    task automatic emit_frame();
        logic       rev_read;
        logic [8:0] pat;
        rev_read = 1'($urandom_range(0, 1));
        emit_group(rev_read ? flip9(DELIM_PATTERN) : DELIM_PATTERN);
        pat = CODE_PATTERNS[$urandom_range(0, 42)];
        // now and then the data comes in the wrong direction
        if (rev_read ^ ($urandom_range(0, 9) == 0)) begin
            pat = flip9(pat);
        end
        emit_group(pat);
        if ($urandom_range(0, 19) == 0) begin
            push_clear();
        end
        emit_group($urandom_range(0, 1) ? flip9(DELIM_PATTERN) : DELIM_PATTERN);
    endtask

    task automatic emit_noise();
        int n;
        if ($urandom_range(0, 1) == 0) begin
            // nine bars of random width
            push_edge(gen_clock + gen_debounce + 1, SENSOR_PIN);
            for (int i = 0; i < 9; i++) begin
                push_edge(gen_clock + gen_debounce + 1 + $urandom_range(0, 4000), SENSOR_PIN);
            end
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0: push_clear();
                    1: push_edge({$urandom, $urandom}, other_pin());
                    2: push_edge({$urandom, $urandom}, SENSOR_PIN);
                    default: push_edge(gen_clock + $urandom_range(0, 3 * gen_debounce + 10),
                                       5'($urandom_range(0, 31)));
                endcase
            end
        end
    endtask

    task automatic fill_random(input int count);
        int first;
        first = pushed_events;
        while (pushed_events - first < count) begin
            if ($urandom_range(0, 99) < 75) begin
                emit_frame();
            end else begin
                emit_noise();
            end
        end
    endtask

    task automatic emit_directed();
        logic [63:0] rev_delim_bars [0:8];
        rev_delim_bars = '{64'd1500, 64'd1500, 64'd5000, 64'd1500, 64'd5000,
                           64'd1500, 64'd1500, 64'h100_0000_0000, 64'd5000};
        push_clear();
        push_edge(64'd5000, 5'd17);
        // exactly the debounce time after the reset timestamp: dropped
        push_edge(64'd1000, SENSOR_PIN);
        // arm just below the wrap point so the bars cross it
        push_edge(64'hFFFF_FFFF_FFFF_F800, SENSOR_PIN);
        // reversed delimiter, one saturated bar, last bar ties a wide one
        for (int i = 0; i < 9; i++) begin
            push_edge(gen_clock + rev_delim_bars[i], SENSOR_PIN);
        end
        // one past the debounce time: accepted
        push_edge(gen_clock + 64'd1001, SENSOR_PIN);
        // nine equal bars, lowest three rank wide
        for (int i = 0; i < 9; i++) begin
            push_edge(gen_clock + 64'd2000, SENSOR_PIN);
        end
        push_clear();
    endtask

    task automatic drain_block();
        while (pending_events.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        p_debounce   = value;
        gen_debounce = value;
    endtask

    initial begin
        for (int i = 0; i < 9; i++) begin
            p_bars[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        emit_directed();
        drain_block();

        write_debounce('0);
        fill_random(330);
        drain_block();

        write_debounce('1);
        send_idle_pct = 63;
        fill_random(330);
        drain_block();

        write_debounce(DEBOUNCE_W'($urandom_range(0, 20'hFFFFF)));
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        fill_random(165);
        // sender holds off until every word is out
        drain_block();
        fill_random(165);
        drain_block();

        write_debounce(DEBOUNCE_W'($urandom_range(1, 5000)));
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        fill_random(330);
        drain_block();

        if (expected_results.size() != 0) begin
            $display("%0d expected words never arrived", expected_results.size());
            fail_count += expected_results.size();
        end
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
